[hw/rtl/dpc_pkg.sv]
// shared types and constants of the droop power controller
package dpc_pkg;

  // sample and arithmetic widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int PWR_W        = 2 * SAMPLE_WIDTH;
  // booth multiplier operand, even width, room for signed samples and unsigned gains
  localparam int MPLR_W       = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 2;
  localparam int DIGITS       = MPLR_W / 2;
  localparam int DIGIT_CNT_W  = $clog2(DIGITS);
  localparam int ACC_W        = ((2 * SAMPLE_WIDTH + 18) > 50) ? (2 * SAMPLE_WIDTH + 18) : 50;
  localparam int FILT_W       = 32;
  localparam int REF_W        = 16;
  localparam int GAIN_W       = 16;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_LPF_NEW_GAIN       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LPF_OLD_GAIN       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_SETPOINT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REACTIVE_SETPOINT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NOMINAL_VOLTAGE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NOMINAL_FREQUENCY  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FREQ_DROOP_GAIN    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLT_DROOP_GAIN    = 3'd7;

  localparam logic [GAIN_W-1:0] LPF_NEW_GAIN_RST = 16'd3277;
  localparam logic [GAIN_W-1:0] LPF_OLD_GAIN_RST = 16'd29491;

  // saturation bounds
  localparam logic signed [ACC_W-1:0]  LPF_MAX  = ACC_W'(1073741824);
  localparam logic signed [ACC_W-1:0]  LPF_MIN  = -LPF_MAX;
  localparam logic signed [ACC_W-1:0]  REF_MAX  = ACC_W'(65535);
  localparam logic signed [FILT_W-1:0] FILT_MAX = 32'sd1073741824;
  localparam logic signed [FILT_W-1:0] FILT_MIN = -FILT_MAX;

  // input beat
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] volt_alpha;
    logic signed [SAMPLE_WIDTH-1:0] volt_beta;
    logic signed [SAMPLE_WIDTH-1:0] curr_alpha;
    logic signed [SAMPLE_WIDTH-1:0] curr_beta;
  } sample_t;

  // output beat
  typedef struct packed {
    logic signed [FILT_W-1:0] active_power_filtered;
    logic signed [FILT_W-1:0] reactive_power_filtered;
    logic [REF_W-1:0]         voltage_reference;
    logic [REF_W-1:0]         frequency_reference;
  } result_t;

  // register file contents
  typedef struct packed {
    logic [GAIN_W-1:0]        lpf_new_gain;
    logic [GAIN_W-1:0]        lpf_old_gain;
    logic signed [FILT_W-1:0] active_power_setpoint;
    logic signed [FILT_W-1:0] reactive_power_setpoint;
    logic [REF_W-1:0]         nominal_voltage;
    logic [REF_W-1:0]         nominal_frequency;
    logic [GAIN_W-1:0]        frequency_droop_gain;
    logic [GAIN_W-1:0]        voltage_droop_gain;
  } cfg_t;

  // command to the serial multiply-accumulate unit
  typedef struct packed {
    logic start;
    logic clear;
    logic negate;
  } mac_cmd_t;

  // sequencer status toward the channel logic
  typedef struct packed {
    logic busy;
    logic res_valid;
  } ctrl_stat_t;

endpackage

[hw/rtl/droop_power_controller_core.sv]
// top level of the droop power controller: registers, channels and sequencer
//
//   channel  | direction | handshake                    | beat
//   ---------+-----------+------------------------------+------------------------------
//   sample   | in        | sample_valid / sample_stall  | dpc_pkg::sample_t
//   result   | out       | result_valid / result_stall  | dpc_pkg::result_t
//   cfg      | in        | cfg_we, no wait              | cfg_index, cfg_data
//
// each sample runs ten products on one radix-4 booth serial multiplier,
// each as issue, 9 digits and capture; the next sample beat is taken only once
// the result has moved to the output register and the sequencer is idle again.
// rst is synchronous: registers return to their reset values, filter state clears.
// a result waits in the output register under result_stall while the next sample
// is already taken; the sequencer only holds when a second result finds it full.
module droop_power_controller_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  dpc_pkg::sample_t                    sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output dpc_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [dpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  dpc_pkg::cfg_t        cfg;
  dpc_pkg::ctrl_stat_t  stat;
  dpc_pkg::result_t     res;
  logic                 start;
  logic                 take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lpf_new_gain            <= dpc_pkg::LPF_NEW_GAIN_RST;
      cfg.lpf_old_gain            <= dpc_pkg::LPF_OLD_GAIN_RST;
      cfg.active_power_setpoint   <= '0;
      cfg.reactive_power_setpoint <= '0;
      cfg.nominal_voltage         <= '0;
      cfg.nominal_frequency       <= '0;
      cfg.frequency_droop_gain    <= '0;
      cfg.voltage_droop_gain      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dpc_pkg::CFG_LPF_NEW_GAIN:      cfg.lpf_new_gain <= cfg_data[15:0];
        dpc_pkg::CFG_LPF_OLD_GAIN:      cfg.lpf_old_gain <= cfg_data[15:0];
        dpc_pkg::CFG_ACTIVE_SETPOINT:   cfg.active_power_setpoint <= cfg_data;
        dpc_pkg::CFG_REACTIVE_SETPOINT: cfg.reactive_power_setpoint <= cfg_data;
        dpc_pkg::CFG_NOMINAL_VOLTAGE:   cfg.nominal_voltage <= cfg_data[15:0];
        dpc_pkg::CFG_NOMINAL_FREQUENCY: cfg.nominal_frequency <= cfg_data[15:0];
        dpc_pkg::CFG_FREQ_DROOP_GAIN:   cfg.frequency_droop_gain <= cfg_data[15:0];
        dpc_pkg::CFG_VOLT_DROOP_GAIN:   cfg.voltage_droop_gain <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // sample beat starts the sequencer
  assign sample_stall = stat.busy;
  assign start        = sample_valid && !sample_stall;

  dpc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .sample (sample),
    .cfg    (cfg),
    .take   (take),
    .stat   (stat),
    .res    (res)
  );

  // output register
  assign take = stat.res_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res;
    end
  end

endmodule

[hw/rtl/dpc_mac.sv]
// radix-4 booth serial multiply-accumulate unit, two multiplier bits per cycle
module dpc_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dpc_pkg::mac_cmd_t                    cmd,
  input  logic signed [dpc_pkg::ACC_W-1:0]     mcand,
  input  logic [dpc_pkg::MPLR_W-1:0]           mplr,
  output logic                                 done,
  output logic signed [dpc_pkg::ACC_W-1:0]     acc
);

  logic                                 busy;
  logic                                 neg;
  logic [dpc_pkg::DIGIT_CNT_W-1:0]      cnt;
  logic signed [dpc_pkg::ACC_W-1:0]     a_sh;
  logic [dpc_pkg::MPLR_W-1:0]           b_sh;
  logic                                 b_prev;
  logic                                 last;
  logic                                 nz;
  logic                                 mag2;
  logic                                 sub;
  logic signed [dpc_pkg::ACC_W-1:0]     term;
  logic signed [dpc_pkg::ACC_W-1:0]     acc_next;

  assign last = (cnt == dpc_pkg::DIGIT_CNT_W'(dpc_pkg::DIGITS - 1));

  // booth digit from the low two bits and the bit shifted out before
  always_comb begin
    nz       = !((b_sh[1] == b_sh[0]) && (b_sh[0] == b_prev));
    mag2     = (b_sh[0] == b_prev) && (b_sh[1] != b_sh[0]);
    sub      = b_sh[1] ^ neg;
    term     = mag2 ? (a_sh <<< 1) : a_sh;
    acc_next = acc;
    if (nz) begin
      acc_next = sub ? (acc - term) : (acc + term);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath shift registers and accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_sh   <= mcand;
      b_sh   <= mplr;
      b_prev <= 1'b0;
      neg    <= cmd.negate;
      if (cmd.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      acc    <= acc_next;
      a_sh   <= a_sh <<< 2;
      b_sh   <= {2'b00, b_sh[dpc_pkg::MPLR_W-1:2]};
      b_prev <= b_sh[1];
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) cmd.start |-> !busy)
    else $error("mac started while busy");
  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("mac done held two cycles");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("mac done while still busy");

endmodule

[hw/rtl/dpc_ctrl.sv]
// sequencer: power products, low-pass filters and droop references on the serial mac
module dpc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  dpc_pkg::sample_t       sample,
  input  dpc_pkg::cfg_t          cfg,
  input  logic                   take,
  output dpc_pkg::ctrl_stat_t    stat,
  output dpc_pkg::result_t       res
);

  localparam int SW = dpc_pkg::SAMPLE_WIDTH;
  localparam int AW = dpc_pkg::ACC_W;
  localparam int MW = dpc_pkg::MPLR_W;
  localparam int PW = dpc_pkg::PWR_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_P1   = 4'd1;
  localparam logic [3:0] ST_P2   = 4'd2;
  localparam logic [3:0] ST_Q1   = 4'd3;
  localparam logic [3:0] ST_Q2   = 4'd4;
  localparam logic [3:0] ST_FP1  = 4'd5;
  localparam logic [3:0] ST_FP2  = 4'd6;
  localparam logic [3:0] ST_FQ1  = 4'd7;
  localparam logic [3:0] ST_FQ2  = 4'd8;
  localparam logic [3:0] ST_DV   = 4'd9;
  localparam logic [3:0] ST_DF   = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  logic [3:0]                      state;
  logic                            pend;
  dpc_pkg::sample_t                smp;
  logic signed [PW-1:0]            pwr_p;
  logic signed [PW-1:0]            pwr_q;
  logic signed [dpc_pkg::FILT_W-1:0] filt_p;
  logic signed [dpc_pkg::FILT_W-1:0] filt_q;
  logic [dpc_pkg::REF_W-1:0]       vref;
  logic [dpc_pkg::REF_W-1:0]       fref;

  dpc_pkg::mac_cmd_t               cmd;
  logic                            working;
  logic signed [AW-1:0]            mcand;
  logic [MW-1:0]                   mplr;
  logic                            mac_done;
  logic signed [AW-1:0]            acc;

  logic signed [AW-1:0]            va_x;
  logic signed [AW-1:0]            vb_x;
  logic [MW-1:0]                   ia_x;
  logic [MW-1:0]                   ib_x;
  logic [MW-1:0]                   gnew_x;
  logic [MW-1:0]                   gold_x;
  logic [MW-1:0]                   ngain_x;
  logic [MW-1:0]                   mgain_x;
  logic signed [32:0]              dev_q;
  logic signed [32:0]              dev_p;
  logic signed [AW-1:0]            sh1;
  logic signed [AW-1:0]            sh15;
  logic signed [AW-1:0]            sh32;
  logic signed [dpc_pkg::FILT_W-1:0] filt_sat;
  logic signed [AW-1:0]            ref_raw;
  logic [dpc_pkg::REF_W-1:0]       ref_sat;

  // operand extension
  assign va_x    = {{(AW-SW){smp.volt_alpha[SW-1]}}, smp.volt_alpha};
  assign vb_x    = {{(AW-SW){smp.volt_beta[SW-1]}}, smp.volt_beta};
  assign ia_x    = {{(MW-SW){smp.curr_alpha[SW-1]}}, smp.curr_alpha};
  assign ib_x    = {{(MW-SW){smp.curr_beta[SW-1]}}, smp.curr_beta};
  assign gnew_x  = {{(MW-dpc_pkg::GAIN_W){1'b0}}, cfg.lpf_new_gain};
  assign gold_x  = {{(MW-dpc_pkg::GAIN_W){1'b0}}, cfg.lpf_old_gain};
  assign ngain_x = {{(MW-dpc_pkg::GAIN_W){1'b0}}, cfg.voltage_droop_gain};
  assign mgain_x = {{(MW-dpc_pkg::GAIN_W){1'b0}}, cfg.frequency_droop_gain};

  // droop deviations, one bit wider than the operands
  assign dev_q = {filt_q[31], filt_q}
               - {cfg.reactive_power_setpoint[31], cfg.reactive_power_setpoint};
  assign dev_p = {filt_p[31], filt_p}
               - {cfg.active_power_setpoint[31], cfg.active_power_setpoint};

  // operand selection per step
  always_comb begin
    mcand      = '0;
    mplr       = '0;
    cmd.clear  = 1'b0;
    cmd.negate = 1'b0;
    working    = 1'b1;
    case (state)
      ST_P1: begin
        mcand     = va_x;
        mplr      = ia_x;
        cmd.clear = 1'b1;
      end
      ST_P2: begin
        mcand = vb_x;
        mplr  = ib_x;
      end
      ST_Q1: begin
        mcand     = vb_x;
        mplr      = ia_x;
        cmd.clear = 1'b1;
      end
      ST_Q2: begin
        mcand      = va_x;
        mplr       = ib_x;
        cmd.negate = 1'b1;
      end
      ST_FP1: begin
        mcand     = {{(AW-PW){pwr_p[PW-1]}}, pwr_p};
        mplr      = gnew_x;
        cmd.clear = 1'b1;
      end
      ST_FP2: begin
        mcand = {{(AW-dpc_pkg::FILT_W){filt_p[31]}}, filt_p};
        mplr  = gold_x;
      end
      ST_FQ1: begin
        mcand     = {{(AW-PW){pwr_q[PW-1]}}, pwr_q};
        mplr      = gnew_x;
        cmd.clear = 1'b1;
      end
      ST_FQ2: begin
        mcand = {{(AW-dpc_pkg::FILT_W){filt_q[31]}}, filt_q};
        mplr  = gold_x;
      end
      ST_DV: begin
        mcand     = {{(AW-33){dev_q[32]}}, dev_q};
        mplr      = ngain_x;
        cmd.clear = 1'b1;
      end
      ST_DF: begin
        mcand     = {{(AW-33){dev_p[32]}}, dev_p};
        mplr      = mgain_x;
        cmd.clear = 1'b1;
      end
      default: begin
        working = 1'b0;
      end
    endcase
    cmd.start = working && !pend;
  end

  dpc_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .mcand (mcand),
    .mplr  (mplr),
    .done  (mac_done),
    .acc   (acc)
  );

  // post-processing of the accumulator
  always_comb begin
    sh1  = acc >>> 1;
    sh15 = acc >>> 15;
    sh32 = acc >>> 32;
    if (sh15 > dpc_pkg::LPF_MAX) begin
      filt_sat = dpc_pkg::FILT_MAX;
    end else if (sh15 < dpc_pkg::LPF_MIN) begin
      filt_sat = dpc_pkg::FILT_MIN;
    end else begin
      filt_sat = sh15[dpc_pkg::FILT_W-1:0];
    end
    if (state == ST_DV) begin
      ref_raw = $signed({{(AW-dpc_pkg::REF_W){1'b0}}, cfg.nominal_voltage}) - sh32;
    end else begin
      ref_raw = $signed({{(AW-dpc_pkg::REF_W){1'b0}}, cfg.nominal_frequency}) - sh32;
    end
    if (ref_raw < 0) begin
      ref_sat = '0;
    end else if (ref_raw > dpc_pkg::REF_MAX) begin
      ref_sat = '1;
    end else begin
      ref_sat = ref_raw[dpc_pkg::REF_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pend   <= 1'b0;
      filt_p <= '0;
      filt_q <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_P1;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          if (cmd.start) begin
            pend <= 1'b1;
          end else if (mac_done) begin
            pend <= 1'b0;
            case (state)
              ST_P1:  state <= ST_P2;
              ST_P2:  state <= ST_Q1;
              ST_Q1:  state <= ST_Q2;
              ST_Q2:  state <= ST_FP1;
              ST_FP1: state <= ST_FP2;
              ST_FP2: begin
                filt_p <= filt_sat;
                state  <= ST_FQ1;
              end
              ST_FQ1: state <= ST_FQ2;
              ST_FQ2: begin
                filt_q <= filt_sat;
                state  <= ST_DV;
              end
              ST_DV:  state <= ST_DF;
              ST_DF:  state <= ST_DONE;
              default: state <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  // sample and intermediate payload
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      smp <= sample;
    end
    if (mac_done && pend) begin
      case (state)
        ST_P2:   pwr_p <= sh1[PW-1:0];
        ST_Q2:   pwr_q <= sh1[PW-1:0];
        ST_DV:   vref  <= ref_sat;
        ST_DF:   fref  <= ref_sat;
        default: begin
        end
      endcase
    end
  end

  assign stat.busy      = (state != ST_IDLE);
  assign stat.res_valid = (state == ST_DONE);

  assign res.active_power_filtered   = filt_p;
  assign res.reactive_power_filtered = filt_q;
  assign res.voltage_reference       = vref;
  assign res.frequency_reference     = fref;

  a_filt_p_range: assert property (@(posedge clk) disable iff (rst)
      (filt_p <= dpc_pkg::FILT_MAX) && (filt_p >= dpc_pkg::FILT_MIN))
    else $error("filtered active power out of range");
  a_filt_q_range: assert property (@(posedge clk) disable iff (rst)
      (filt_q <= dpc_pkg::FILT_MAX) && (filt_q >= dpc_pkg::FILT_MIN))
    else $error("filtered reactive power out of range");
  a_done_pending: assert property (@(posedge clk) disable iff (rst) mac_done |-> pend)
    else $error("mac result with no product pending");
  a_start_seq: assert property (@(posedge clk) disable iff (rst)
      ((state == ST_IDLE) && start) |=> ((state == ST_P1) && !pend))
    else $error("accepted sample did not start the sequence");
  a_res_quiet: assert property (@(posedge clk) disable iff (rst) stat.res_valid |-> !pend)
    else $error("result offered while a product is pending");

endmodule
